// File: hdl/ssc_pkg.sv
// shared types and constants for the sphere-sphere contact pipeline
// no dependencies
`default_nettype none
package ssc_pkg;

	localparam int SQ_W        = 66;  // sum of three squared differences
	localparam int RAD_W       = 68;  // radicand padded to an even width
	localparam int ROOT_W      = 34;
	localparam int SQRT_STAGES = RAD_W / 2;
	localparam int SREM_W      = ROOT_W + 2;
	localparam int Q_W         = 31;  // quotient bits, value at most 2^30
	localparam int DIV_STAGES  = Q_W;
	localparam int DREM_W      = ROOT_W;
	localparam int MAG_W       = 33;
	localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

	typedef struct packed {
		logic signed [31:0] first_center_x;
		logic signed [31:0] first_center_y;
		logic signed [31:0] first_center_z;
		logic        [30:0] first_radius;
		logic signed [31:0] second_center_x;
		logic signed [31:0] second_center_y;
		logic signed [31:0] second_center_z;
		logic        [30:0] second_radius;
	} in_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic signed [31:0] depth;
		logic signed [31:0] contact_x;
		logic signed [31:0] contact_y;
		logic signed [31:0] contact_z;
	} out_t;

	typedef struct packed {
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0]            neg;
		logic [2:0][32:0]      csum;
		logic [30:0]           r1;
		logic [30:0]           r2;
	} sqrt_sb_t;

	typedef struct packed {
		logic                  hit;
		logic                  zero;
		logic [2:0]            neg;
		logic [2:0][32:0]      csum;
		logic signed [31:0]    rdiff;
		logic signed [31:0]    depth;
	} div_sb_t;

endpackage
`default_nettype wire

// File: hdl/ssc_sqrt.sv
// pipelined integer square root, one result bit per stage
// depends on ssc_pkg
`default_nettype none
module ssc_sqrt import ssc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [SQ_W-1:0]   rad,
	input  wire sqrt_sb_t          sb_in,
	output logic                   out_valid,
	output logic [ROOT_W-1:0]      root,
	output sqrt_sb_t               sb_out
);

	logic [SQRT_STAGES-1:0] vld_s;
	logic [RAD_W-1:0]       rad_s  [SQRT_STAGES];
	logic [SREM_W-1:0]      rem_s  [SQRT_STAGES];
	logic [ROOT_W-1:0]      root_s [SQRT_STAGES];
	sqrt_sb_t               sb_s   [SQRT_STAGES];

	logic [RAD_W-1:0]  rad_n  [SQRT_STAGES];
	logic [SREM_W-1:0] rem_n  [SQRT_STAGES];
	logic [ROOT_W-1:0] root_n [SQRT_STAGES];

	always_comb begin
		logic [RAD_W-1:0]  src_rad;
		logic [SREM_W-1:0] src_rem;
		logic [ROOT_W-1:0] src_root;
		logic [SREM_W+1:0] cat;
		logic [SREM_W+1:0] sub;
		logic [SREM_W+1:0] diff;
		for (int i = 0; i < SQRT_STAGES; i++) begin
			if (i == 0) begin
				src_rad  = {{(RAD_W-SQ_W){1'b0}}, rad};
				src_rem  = '0;
				src_root = '0;
			end else begin
				src_rad  = rad_s[i-1];
				src_rem  = rem_s[i-1];
				src_root = root_s[i-1];
			end
			cat  = {src_rem, src_rad[RAD_W-1 -: 2]};
			sub  = {2'b00, src_root, 2'b01};
			diff = cat - sub;
			if (cat >= sub) begin
				rem_n[i]  = diff[SREM_W-1:0];
				root_n[i] = {src_root[ROOT_W-2:0], 1'b1};
			end else begin
				rem_n[i]  = cat[SREM_W-1:0];
				root_n[i] = {src_root[ROOT_W-2:0], 1'b0};
			end
			rad_n[i] = {src_rad[RAD_W-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[SQRT_STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		sb_s[0] <= sb_in;
		for (int i = 0; i < SQRT_STAGES; i++) begin
			rad_s[i]  <= rad_n[i];
			rem_s[i]  <= rem_n[i];
			root_s[i] <= root_n[i];
		end
		for (int i = 1; i < SQRT_STAGES; i++) begin
			sb_s[i] <= sb_s[i-1];
		end
	end

	assign out_valid = vld_s[SQRT_STAGES-1];
	assign root      = root_s[SQRT_STAGES-1];
	assign sb_out    = sb_s[SQRT_STAGES-1];

endmodule
`default_nettype wire

// File: hdl/ssc_div.sv
// pipelined restoring divider, three lanes sharing one divisor
// computes (mag << 30) / dvs one quotient bit per stage; depends on ssc_pkg
`default_nettype none
module ssc_div import ssc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic [2:0][MAG_W-1:0] mag,
	input  wire logic [ROOT_W-1:0]     dvs,
	input  wire div_sb_t               sb_in,
	output logic                       out_valid,
	output logic [2:0][Q_W-1:0]        quo,
	output div_sb_t                    sb_out
);

	logic [DIV_STAGES-1:0]   vld_s;
	logic [ROOT_W-1:0]       dvs_s [DIV_STAGES];
	logic [2:0][DREM_W-1:0]  rem_s [DIV_STAGES];
	logic [2:0][Q_W-1:0]     q_s   [DIV_STAGES];
	div_sb_t                 sb_s  [DIV_STAGES];

	logic [2:0][DREM_W-1:0]  rem_n [DIV_STAGES];
	logic [2:0][Q_W-1:0]     q_n   [DIV_STAGES];

	always_comb begin
		logic [ROOT_W-1:0] src_dvs;
		logic [DREM_W-1:0] src_rem;
		logic [Q_W-1:0]    src_q;
		logic              nbit;
		logic [DREM_W:0]   cat;
		logic [DREM_W:0]   diff;
		for (int i = 0; i < DIV_STAGES; i++) begin
			for (int k = 0; k < 3; k++) begin
				// the remainder starts from the dividend's top bits, which stay below the divisor
				if (i == 0) begin
					src_dvs = dvs;
					src_rem = {{(DREM_W-MAG_W+1){1'b0}}, mag[k][MAG_W-1:1]};
					src_q   = '0;
					nbit    = mag[k][0];
				end else begin
					src_dvs = dvs_s[i-1];
					src_rem = rem_s[i-1][k];
					src_q   = q_s[i-1][k];
					nbit    = 1'b0;
				end
				cat  = {src_rem, nbit};
				diff = cat - {1'b0, src_dvs};
				if (cat >= {1'b0, src_dvs}) begin
					rem_n[i][k] = diff[DREM_W-1:0];
					q_n[i][k]   = {src_q[Q_W-2:0], 1'b1};
				end else begin
					rem_n[i][k] = cat[DREM_W-1:0];
					q_n[i][k]   = {src_q[Q_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[DIV_STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		dvs_s[0] <= dvs;
		sb_s[0]  <= sb_in;
		for (int i = 0; i < DIV_STAGES; i++) begin
			rem_s[i] <= rem_n[i];
			q_s[i]   <= q_n[i];
		end
		for (int i = 1; i < DIV_STAGES; i++) begin
			dvs_s[i] <= dvs_s[i-1];
			sb_s[i]  <= sb_s[i-1];
		end
	end

	assign out_valid = vld_s[DIV_STAGES-1];
	assign quo       = q_s[DIV_STAGES-1];
	assign sb_out    = sb_s[DIV_STAGES-1];

endmodule
`default_nettype wire

// File: hdl/sphere_sphere_contact.sv
// Sphere-sphere contact test. One pair is accepted every cycle (busy is always low) and its
// result appears with a one-cycle done strobe after stages s1 to s4, the 34-stage square
// root, stage s5, the 31-stage normal divider and stages s6 to s8. The receiver cannot
// hold results off, so every done strobe must be captured when it occurs.
// depends on ssc_pkg, ssc_sqrt, ssc_div
`default_nettype none
module sphere_sphere_contact import ssc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire in_t  in,
	output logic      done,
	output out_t      result
);

	localparam int LATENCY = 4 + SQRT_STAGES + 1 + DIV_STAGES + 3;

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// s1: center differences and sums
	logic                   vld_s1;
	logic signed [32:0]     d_s1    [3];
	logic [2:0][32:0]       csum_s1;
	logic [30:0]            r1_s1, r2_s1;

	logic signed [31:0] c1 [3];
	logic signed [31:0] c2 [3];
	assign c1[0] = in.first_center_x;
	assign c1[1] = in.first_center_y;
	assign c1[2] = in.first_center_z;
	assign c2[0] = in.second_center_x;
	assign c2[1] = in.second_center_y;
	assign c2[2] = in.second_center_z;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			d_s1[k]    <= 33'(c2[k]) - 33'(c1[k]);
			csum_s1[k] <= 33'(c2[k]) + 33'(c1[k]);
		end
		r1_s1 <= in.first_radius;
		r2_s1 <= in.second_radius;
	end

	// s2: magnitudes
	logic                  vld_s2;
	logic [2:0][MAG_W-1:0] mag_s2;
	logic [2:0]            neg_s2;
	logic [2:0][32:0]      csum_s2;
	logic [30:0]           r1_s2, r2_s2;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			neg_s2[k] <= d_s1[k][32];
			mag_s2[k] <= d_s1[k][32] ? MAG_W'(-d_s1[k]) : MAG_W'(d_s1[k]);
		end
		csum_s2 <= csum_s1;
		r1_s2   <= r1_s1;
		r2_s2   <= r2_s1;
	end

	// s3: squares
	logic                 vld_s3;
	logic [2:0][SQ_W-1:0] sq_s3;
	sqrt_sb_t             sb_s3;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			sq_s3[k] <= SQ_W'(mag_s2[k] * mag_s2[k]);
		end
		sb_s3.mag  <= mag_s2;
		sb_s3.neg  <= neg_s2;
		sb_s3.csum <= csum_s2;
		sb_s3.r1   <= r1_s2;
		sb_s3.r2   <= r2_s2;
	end

	// s4: sum of squares
	logic            vld_s4;
	logic [SQ_W-1:0] ssum_s4;
	sqrt_sb_t        sb_s4;

	always_ff @(posedge clk) begin
		ssum_s4 <= sq_s3[0] + sq_s3[1] + sq_s3[2];
		sb_s4   <= sb_s3;
	end

	logic              sq_valid;
	logic [ROOT_W-1:0] sq_root;
	sqrt_sb_t          sq_sb;

	ssc_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.rad       (ssum_s4),
		.sb_in     (sb_s4),
		.out_valid (sq_valid),
		.root      (sq_root),
		.sb_out    (sq_sb)
	);

	// s5: hit test and depth
	logic               vld_s5;
	logic [2:0][MAG_W-1:0] mag_s5;
	logic [ROOT_W-1:0]  dist_s5;
	div_sb_t            sb_s5;

	logic [31:0]        rsum;
	logic signed [35:0] depth_full;
	assign rsum       = 32'(sq_sb.r1) + 32'(sq_sb.r2);
	assign depth_full = 36'(sq_root) - 36'(rsum);

	always_ff @(posedge clk) begin
		mag_s5       <= sq_sb.mag;
		dist_s5      <= sq_root;
		sb_s5.hit    <= sq_root <= ROOT_W'(rsum);
		sb_s5.zero   <= sq_root == '0;
		sb_s5.neg    <= sq_sb.neg;
		sb_s5.csum   <= sq_sb.csum;
		sb_s5.rdiff  <= 32'(sq_sb.r1) - 32'(sq_sb.r2);
		if (depth_full < -36'sd2147483648) begin
			sb_s5.depth <= -32'sd2147483648;
		end else begin
			sb_s5.depth <= depth_full[31:0];
		end
	end

	logic               dv_valid;
	logic [2:0][Q_W-1:0] quo;
	div_sb_t            dv_sb;

	ssc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s5),
		.mag       (mag_s5),
		.dvs       (dist_s5),
		.sb_in     (sb_s5),
		.out_valid (dv_valid),
		.quo       (quo),
		.sb_out    (dv_sb)
	);

	// s6: signed normal, zero when centers coincide
	logic               vld_s6;
	logic signed [31:0] m_s6 [3];
	div_sb_t            sb_s6;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (dv_sb.zero) begin
				m_s6[k] <= '0;
			end else if (dv_sb.neg[k]) begin
				m_s6[k] <= -32'({1'b0, quo[k]});
			end else begin
				m_s6[k] <= 32'({1'b0, quo[k]});
			end
		end
		sb_s6 <= dv_sb;
	end

	// s7: offset product
	logic               vld_s7;
	logic signed [63:0] prod_s7 [3];
	logic signed [31:0] m_s7    [3];
	div_sb_t            sb_s7;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			prod_s7[k] <= 64'(m_s6[k]) * 64'(sb_s6.rdiff);
		end
		m_s7  <= m_s6;
		sb_s7 <= sb_s6;
	end

	// s8: midpoint, saturation, default normal for coincident centers, miss zeroing
	logic signed [33:0] off  [3];
	logic signed [35:0] psum [3];
	logic signed [34:0] half [3];
	logic signed [31:0] cpt  [3];
	logic signed [31:0] nrm  [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			off[k]  = 34'(prod_s7[k] >>> 30);
			psum[k] = 36'($signed(sb_s7.csum[k])) + 36'(off[k]);
			half[k] = 35'(psum[k] >>> 1);
			if (half[k] > 35'sd2147483647) begin
				cpt[k] = 32'sd2147483647;
			end else if (half[k] < -35'sd2147483648) begin
				cpt[k] = -32'sd2147483648;
			end else begin
				cpt[k] = half[k][31:0];
			end
			nrm[k] = m_s7[k];
		end
		if (sb_s7.zero) begin
			nrm[0] = '0;
			nrm[1] = ONE_Q30;
			nrm[2] = '0;
		end
	end

	logic vld_s8;
	out_t res_s8;

	always_ff @(posedge clk) begin
		if (sb_s7.hit) begin
			res_s8.hit       <= 1'b1;
			res_s8.normal_x  <= nrm[0];
			res_s8.normal_y  <= nrm[1];
			res_s8.normal_z  <= nrm[2];
			res_s8.depth     <= sb_s7.depth;
			res_s8.contact_x <= cpt[0];
			res_s8.contact_y <= cpt[1];
			res_s8.contact_z <= cpt[2];
		end else begin
			res_s8 <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= sq_valid;
			vld_s6 <= dv_valid;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	assign done   = vld_s8;
	assign result = res_s8;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without a matching start");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |-> (result == '0))
		else $error("miss result carries nonzero fields");

	a_depth_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.hit) |-> (result.depth <= 32'sd0))
		else $error("hit with positive depth");

	a_normal_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.normal_x <= ONE_Q30 && result.normal_x >= -ONE_Q30 &&
			result.normal_y <= ONE_Q30 && result.normal_y >= -ONE_Q30 &&
			result.normal_z <= ONE_Q30 && result.normal_z >= -ONE_Q30))
		else $error("normal component beyond unit");

endmodule
`default_nettype wire
